@@ rtl/core/wcs_pkg.sv @@
// Shared constants, types and the controller/datapath command and status structs
// for the sliding-window current statistics block. No dependencies.
`default_nettype none
package wcs_pkg;
    localparam int WindowDepth = 64;
    localparam int AddrW = $clog2(WindowDepth);
    localparam int CountW = $clog2(WindowDepth + 1);
    localparam int SampleW = 16;
    localparam int SumW = SampleW + AddrW + 1;
    localparam int SqW = 2 * SampleW + AddrW + 1;
    localparam int DivW = SqW;
    localparam logic [SampleW-1:0] MinEmpty = '1;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_WRITE = 9'b000000010,
        ST_PASS1 = 9'b000000100,
        ST_DIV1  = 9'b000001000,
        ST_PASS2 = 9'b000010000,
        ST_DIV2  = 9'b000100000,
        ST_SQRT  = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_WAIT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic clear;      // empty the window
        logic write;      // store the incoming sample
        logic pass_start; // reset pass index and done flag; latch mean
        logic pass1_step; // accumulate sum, min, max
        logic pass2_step; // accumulate squared deviations
        logic div1_start; // sum / count
        logic div2_start; // sq / count
        logic sqrt_start;
        logic iter_step;  // one iteration of divider or root
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic pass_done;
        logic iter_done;
        logic empty;
    } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/wcs_ctrl.sv @@
// Controller state machine for window statistics; sequences the datapath.
// Depends on wcs_pkg.
`default_nettype none
module wcs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           in_kind,
    output logic                out_valid,
    input  wire logic           out_stall,
    output wcs_pkg::cmd_t       cmd,
    input  wire wcs_pkg::stat_t stat
);
    wcs_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != wcs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            wcs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == wcs_pkg::KIND_CLEAR)
                        cmd.clear = 1'b1;
                    state_next = wcs_pkg::ST_WRITE;
                end
            end
            wcs_pkg::ST_WRITE:
            begin
                cmd.pass_start = 1'b1;
                state_next = wcs_pkg::ST_PASS1;
            end
            wcs_pkg::ST_PASS1:
            begin
                if (stat.empty || stat.pass_done)
                begin
                    cmd.div1_start = 1'b1;
                    state_next = wcs_pkg::ST_DIV1;
                end
                else
                    cmd.pass1_step = 1'b1;
            end
            wcs_pkg::ST_DIV1:
            begin
                if (stat.iter_done)
                begin
                    cmd.pass_start = 1'b1;
                    state_next = wcs_pkg::ST_PASS2;
                end
                else
                    cmd.iter_step = 1'b1;
            end
            wcs_pkg::ST_PASS2:
            begin
                if (stat.empty || stat.pass_done)
                begin
                    cmd.div2_start = 1'b1;
                    state_next = wcs_pkg::ST_DIV2;
                end
                else
                    cmd.pass2_step = 1'b1;
            end
            wcs_pkg::ST_DIV2:
            begin
                if (stat.iter_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = wcs_pkg::ST_SQRT;
                end
                else
                    cmd.iter_step = 1'b1;
            end
            wcs_pkg::ST_SQRT:
            begin
                if (stat.iter_done)
                    state_next = wcs_pkg::ST_WAIT;
                else
                    cmd.iter_step = 1'b1;
            end
            wcs_pkg::ST_WAIT:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || !out_stall)
                    state_next = wcs_pkg::ST_OUT;
            end
            wcs_pkg::ST_OUT:
            begin
                cmd.load_out = 1'b1;
                out_valid_next = 1'b1;
                state_next = wcs_pkg::ST_IDLE;
            end
            default:
                state_next = wcs_pkg::ST_IDLE;
        endcase
        // append write happens in the cycle the request is accepted
        if (state_reg == wcs_pkg::ST_IDLE && in_valid && in_kind == wcs_pkg::KIND_APPEND)
            cmd.write = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/wcs_dp.sv @@
// Datapath: sample memory, window pointers, accumulators, shared iterative
// divider and square root, and output registers. Depends on wcs_pkg.
`default_nettype none
module wcs_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [wcs_pkg::SampleW-1:0]   sample,
    input  wire wcs_pkg::cmd_t                 cmd,
    output wcs_pkg::stat_t                     stat,
    output logic [wcs_pkg::CountW-1:0]         count,
    output logic [wcs_pkg::SampleW-1:0]        mean,
    output logic [wcs_pkg::SampleW-1:0]        std_dev,
    output logic [wcs_pkg::SampleW-1:0]        minimum,
    output logic [wcs_pkg::SampleW-1:0]        maximum
);
    localparam int AW = wcs_pkg::AddrW;
    localparam int CW = wcs_pkg::CountW;
    localparam int SW = wcs_pkg::SampleW;
    localparam int DW = wcs_pkg::DivW;
    localparam int RW = DW / 2 + 1;
    localparam int RadW = 2 * RW;
    localparam int DivSteps = DW;
    localparam int SqrtSteps = RW;
    localparam int StepW = $clog2(DivSteps + 1);

    logic [SW-1:0] mem [wcs_pkg::WindowDepth];
    logic [SW-1:0] rd_data_reg;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_valid_reg;
    logic          done_reg;
    logic [wcs_pkg::SumW-1:0] sum_reg;
    logic [wcs_pkg::SqW-1:0]  sq_reg;
    logic [SW-1:0] min_reg, max_reg, mean_reg;
    logic [DW-1:0] quo_reg, rem_reg;
    logic [RadW-1:0] rad_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] sqrem_reg;
    logic [StepW-1:0] step_reg;
    logic          sqrt_mode_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          full;

    assign full = (held_reg == CW'(wcs_pkg::WindowDepth));
    assign wr_addr = full ? oldest_reg : AW'({1'b0, oldest_reg} + held_reg);
    assign rd_addr = AW'({1'b0, oldest_reg} + idx_reg);

    // sample memory
    always_ff @(posedge clk)
    begin
        if (cmd.write)
            mem[wr_addr] <= sample;
        rd_data_reg <= mem[rd_addr];
    end

    // window pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg <= '0;
        end
        else if (cmd.clear)
        begin
            oldest_reg <= '0;
            held_reg <= '0;
        end
        else if (cmd.write)
        begin
            if (full)
                oldest_reg <= AW'(oldest_reg + 1'b1);
            else
                held_reg <= CW'(held_reg + 1'b1);
        end
    end

    // pass index: read issued at idx, data used in the next cycle
    assign stat.pass_done = done_reg;
    assign stat.empty = (held_reg == '0);

    logic [SW-1:0] diff;
    assign diff = (rd_data_reg >= mean_reg) ? SW'(rd_data_reg - mean_reg)
                                            : SW'(mean_reg - rd_data_reg);
    logic [2*SW-1:0] diff_sq;
    assign diff_sq = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (cmd.pass_start)
        begin
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (cmd.pass1_step || cmd.pass2_step)
        begin
            // idx holds at the count; the final datum is used the cycle before done
            if (idx_reg != held_reg)
                idx_reg <= CW'(idx_reg + 1'b1);
            if (rd_valid_reg && idx_reg == held_reg)
            begin
                rd_valid_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                rd_valid_reg <= 1'b1;
        end
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.write || cmd.clear)
        begin
            sum_reg <= '0;
            sq_reg <= '0;
            min_reg <= wcs_pkg::MinEmpty;
            max_reg <= '0;
        end
        else if (cmd.pass1_step && rd_valid_reg)
        begin
            sum_reg <= sum_reg + wcs_pkg::SumW'(rd_data_reg);
            if (rd_data_reg < min_reg)
                min_reg <= rd_data_reg;
            if (rd_data_reg > max_reg)
                max_reg <= rd_data_reg;
        end
        else if (cmd.pass2_step && rd_valid_reg)
            sq_reg <= sq_reg + wcs_pkg::SqW'(diff_sq);
    end

    // shared restoring divider and bitwise square root
    logic [DW:0] trial;
    assign trial = {rem_reg, quo_reg[DW-1]} - {{(DW+1-CW){1'b0}}, held_reg};
    logic [RW+1:0] sq_trial;
    assign sq_trial = {sqrem_reg[RW-1:0], rad_reg[RadW-1:RadW-2]}
                      - {root_reg, 2'b01};

    assign stat.iter_done = (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            sqrt_mode_reg <= 1'b0;
        end
        else if (cmd.div1_start || cmd.div2_start)
        begin
            step_reg <= stat.empty ? '0 : StepW'(DivSteps);
            sqrt_mode_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            step_reg <= StepW'(SqrtSteps);
            sqrt_mode_reg <= 1'b1;
        end
        else if (cmd.iter_step && step_reg != '0)
            step_reg <= StepW'(step_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div1_start)
        begin
            quo_reg <= DW'(sum_reg);
            rem_reg <= '0;
        end
        else if (cmd.div2_start)
        begin
            quo_reg <= sq_reg;
            rem_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            // radicand widened to an even bit count
            rad_reg <= stat.empty ? '0 : RadW'(quo_reg);
            root_reg <= '0;
            sqrem_reg <= '0;
        end
        else if (cmd.iter_step && step_reg != '0)
        begin
            if (sqrt_mode_reg)
            begin
                rad_reg <= {rad_reg[RadW-3:0], 2'b00};
                if (!sq_trial[RW+1])
                begin
                    sqrem_reg <= sq_trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    sqrem_reg <= {sqrem_reg[RW-1:0], rad_reg[RadW-1:RadW-2]};
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            else if (!trial[DW])
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    // mean latched at each pass start; the value taken when the first division ends is kept
    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
            mean_reg <= stat.empty ? '0 : SW'(quo_reg);
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            count <= held_reg;
            mean <= mean_reg;
            std_dev <= stat.empty ? '0 : SW'(root_reg);
            minimum <= min_reg;
            maximum <= max_reg;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/window_current_statistics_top.sv @@
// Top level of the sliding-window current statistics block.
// Depends on wcs_pkg, wcs_ctrl and wcs_dp.
`default_nettype none
// Keeps the last 64 current samples; each request (append or clear) yields
// one result with count, truncated mean, population deviation, min and max.
// One request at a time: two passes over the sample memory (one read port),
// two 39-step serial divisions and a 20-step root, then the wait and load
// states; an empty window skips the passes and the divisions. A result
// still stalled at the output holds the block in its wait state before the
// next result loads.
// An empty window reports mean 0, deviation 0, minimum 65535, maximum 0.
module window_current_statistics_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       count,
    output logic [15:0]      mean,
    output logic [15:0]      std_dev,
    output logic [15:0]      minimum,
    output logic [15:0]      maximum
);
    wcs_pkg::cmd_t  cmd;
    wcs_pkg::stat_t stat;

    wcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_kind(kind), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    wcs_dp u_dp (
        .clk(clk), .rst_n(rst_n), .sample(sample), .cmd(cmd), .stat(stat),
        .count(count), .mean(mean), .std_dev(std_dev),
        .minimum(minimum), .maximum(maximum)
    );

    // result consistency on a valid output, and busy after an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == '0 |-> mean == '0 && maximum == '0)
        else $error("empty window result not cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count != '0 |-> minimum <= mean && mean <= maximum)
        else $error("mean outside min/max");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");
endmodule
`default_nettype wire

@@ dv/wcs_checker.sv @@
// Checker for the sliding-window current statistics block: watches both channels,
// keeps its own window, predicts each result and compares. Depends on wcs_pkg.
`default_nettype none
module wcs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] sample,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [6:0]  count,
    input  wire logic [15:0] mean,
    input  wire logic [15:0] std_dev,
    input  wire logic [15:0] minimum,
    input  wire logic [15:0] maximum,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [6:0]  count;
        logic [15:0] mean;
        logic [15:0] std_dev;
        logic [15:0] minimum;
        logic [15:0] maximum;
    } stats_t;

    logic [15:0] window_q [wcs_pkg::WindowDepth];
    int unsigned oldest_idx;
    int unsigned held;
    stats_t      stats_q [$];

    // bitwise floor square root
    function automatic logic [31:0] isqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    // update the window with one request and compute the statistics
    function automatic stats_t window_stats(input logic k, input logic [15:0] s);
        stats_t r;
        logic [63:0] sum;
        logic [63:0] sq;
        logic [63:0] d;
        logic [31:0] avg;
        logic [31:0] root;
        logic [15:0] x;
        logic [15:0] lo;
        logic [15:0] hi;
        sum = 0;
        sq = 0;
        avg = 0;
        lo = wcs_pkg::MinEmpty;
        hi = 0;
        r = '0;
        if (k == wcs_pkg::KIND_CLEAR)
        begin
            held = 0;
            oldest_idx = 0;
        end
        else if (held >= wcs_pkg::WindowDepth)
        begin
            window_q[oldest_idx] = s;
            oldest_idx = (oldest_idx + 1) % wcs_pkg::WindowDepth;
        end
        else
        begin
            window_q[(oldest_idx + held) % wcs_pkg::WindowDepth] = s;
            held++;
        end
        if (held != 0)
        begin
            for (int i = 0; i < held; i++)
            begin
                x = window_q[(oldest_idx + i) % wcs_pkg::WindowDepth];
                sum += x;
                if (x < lo) lo = x;
                if (x > hi) hi = x;
            end
            avg = 32'(sum / held);
            for (int i = 0; i < held; i++)
            begin
                x = window_q[(oldest_idx + i) % wcs_pkg::WindowDepth];
                d = (x >= avg) ? x - avg : avg - x;
                sq += d * d;
            end
            root = isqrt(sq / held);
            r.std_dev = root[15:0];
        end
        r.count = held[6:0];
        r.mean = avg[15:0];
        r.minimum = lo;
        r.maximum = hi;
        return r;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        stats_t got;
        stats_t exp_r;
        if (!rst_n)
        begin
            held = 0;
            oldest_idx = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                stats_q.push_back(window_stats(kind, sample));
            if (out_valid && !out_stall)
            begin
                got = {count, mean, std_dev, minimum, maximum};
                if (stats_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = stats_q.pop_front();
                    if (got !== exp_r)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch cnt %0d/%0d mean %0d/%0d dev %0d/%0d",
                                      " min %0d/%0d max %0d/%0d"},
                                     exp_r.count, count, exp_r.mean, mean,
                                     exp_r.std_dev, std_dev,
                                     exp_r.minimum, minimum, exp_r.maximum, maximum);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= stats_q.size();
        end
    end
endmodule
`default_nettype wire

@@ dv/tb_window_current_statistics_top.sv @@
// Testbench top for the sliding-window current statistics block: clock, reset,
// request stimulus with idling phases and verdict. Depends on wcs_pkg and wcs_checker.
`default_nettype none
module tb_window_current_statistics_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        kind = wcs_pkg::KIND_APPEND;
    logic [15:0] sample = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [6:0]  count;
    logic [15:0] mean;
    logic [15:0] std_dev;
    logic [15:0] minimum;
    logic [15:0] maximum;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #5 clk = ~clk;

    window_current_statistics_top dut (.*);

    wcs_checker chk (.*);

    // receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // issue one request, idling first per phase; valid stays up until the next idle
    task automatic send_req(input logic k, input logic [15:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        kind <= k;
        sample <= s;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drop valid and wait until every expected result has come
    task automatic drain();
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // random sample: a quarter each near 0, near 65535, near 0x4000 and over the full range
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(15));
            1: return 16'(16'hFFFF - $urandom_range(15));
            2: return 16'(16'h4000 + $urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty clear, extremes, lone sample, fill past full, clear
        send_req(wcs_pkg::KIND_CLEAR, 16'hFFFF);
        send_req(wcs_pkg::KIND_APPEND, 16'h0000);
        send_req(wcs_pkg::KIND_APPEND, 16'hFFFF);
        send_req(wcs_pkg::KIND_CLEAR, 16'h0000);
        send_req(wcs_pkg::KIND_APPEND, 16'hFFFF);
        send_req(wcs_pkg::KIND_APPEND, 16'hFFFF);
        send_req(wcs_pkg::KIND_APPEND, 16'h0001);
        send_req(wcs_pkg::KIND_CLEAR, 16'h5555);
        for (int i = 0; i < 80; i++)
            send_req(wcs_pkg::KIND_APPEND, (i % 2) ? 16'hFFFF : 16'h0000);
        send_req(wcs_pkg::KIND_CLEAR, 16'hAAAA);
        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 33 : 0;
            recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 33 : 0;
            for (int n = 0; n < 415; n++)
                send_req(($urandom_range(79) == 0) ? wcs_pkg::KIND_CLEAR
                                                   : wcs_pkg::KIND_APPEND,
                         rand_sample());
            // drain before the next phase
            drain();
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
